FILE: design/alkd_pkg.sv
// Shared types, key codes, window bounds and register indexes for the ladder key decoder.
package alkd_pkg;

  localparam int SampleWidth = 16;
  localparam int KeyWidth    = 3;
  localparam int CfgIdxWidth = 1;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [KeyWidth-1:0]    key_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam key_t KC_NONE  = 3'd0;
  localparam key_t KC_POWER = 3'd1;
  localparam key_t KC_MODE  = 3'd2;
  localparam key_t KC_SET   = 3'd3;
  localparam key_t KC_PRINT = 3'd4;
  localparam key_t KC_TARE  = 3'd5;
  localparam key_t KC_CAL   = 3'd6;

  localparam cfg_idx_t CFG_KEYS_ENABLED  = 1'b0;
  localparam cfg_idx_t CFG_RELEASE_LEVEL = 1'b1;

  localparam sample_t RELEASE_LEVEL_RST = 16'h2000;

  // Window bounds, both exclusive.
  localparam sample_t POWER_LO = 16'h2A00;
  localparam sample_t POWER_HI = 16'h2EFF;
  localparam sample_t MODE_LO  = 16'h5400;
  localparam sample_t MODE_HI  = 16'h55FF;
  localparam sample_t SET_LO   = 16'hFD00;
  localparam sample_t SET_HI   = 16'hFEFF;
  localparam sample_t PRINT_LO = 16'h7A00;
  localparam sample_t PRINT_HI = 16'h7CFF;
  localparam sample_t TARE_LO  = 16'hA100;
  localparam sample_t TARE_HI  = 16'hA3FF;
  localparam sample_t CAL_LO   = 16'hCC00;
  localparam sample_t CAL_HI   = 16'hCDFF;

  function automatic logic in_window(sample_t s, sample_t lo, sample_t hi);
    return (s > lo) && (s < hi);
  endfunction

endpackage

FILE: design/adc_ladder_key_decoder_core.sv
// Top level of the ladder key decoder: input register, classify and debounce, result register.
//
//   channel | dir | handshake            | payload
//   s_*     | in  | s_tvalid / s_tready  | s_tdata[15:0] sample
//   m_*     | out | m_tvalid / m_tready  | m_tdata[2:0] key_code
//   cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data[15:0]
//
// One beat in, one beat out; a new sample can be taken every cycle while the result is not stalled.
// A sample passes the input register, then the history/latch update into the result register.
// Reset (rst, synchronous) clears history, latch, report and both valid flags;
// s_tready and cfg_ready stay low during reset, and cfg_ready is high otherwise.
// A stalled result holds in the output register; the input register still takes a beat only if it is empty.
module adc_ladder_key_decoder_core import alkd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [2:0] key_code, [7:3] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_idx_t   cfg_index,
  input  logic [15:0] cfg_data
);

  logic    keys_enabled;
  sample_t release_level;

  sample_t sample_q;
  logic    in_valid;
  logic    advance;

  key_t    key_history [3];
  logic    press_latched;
  key_t    held_report;
  key_t    key_match;

  key_t    held_report_next;
  logic    press_latched_next;
  logic    shift_history;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_enabled  <= 1'b0;
      release_level <= RELEASE_LEVEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEYS_ENABLED:  keys_enabled  <= cfg_data[0];
        CFG_RELEASE_LEVEL: release_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move the input beat on whenever the result register is free or being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      sample_q <= s_tdata;
    end
  end

  alkd_classify u_classify (
    .sample       (sample_q),
    .keys_enabled (keys_enabled),
    .key_code     (key_match)
  );

  always_comb begin
    held_report_next   = held_report;
    press_latched_next = press_latched;
    shift_history      = 1'b0;
    if (sample_q < release_level) begin
      held_report_next   = KC_NONE;
      press_latched_next = 1'b0;
    end else if (sample_q > release_level && !press_latched) begin
      if (key_match != KC_NONE) begin
        shift_history = 1'b1;
        if (key_history[0] == key_match && key_history[1] == key_match) begin
          held_report_next   = key_match;
          press_latched_next = 1'b1;
        end
      end
    end else begin
      held_report_next = KC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_history[0] <= KC_NONE;
      key_history[1] <= KC_NONE;
      key_history[2] <= KC_NONE;
      press_latched  <= 1'b0;
      held_report    <= KC_NONE;
    end else if (advance) begin
      press_latched <= press_latched_next;
      held_report   <= held_report_next;
      if (shift_history) begin
        key_history[2] <= key_history[1];
        key_history[1] <= key_history[0];
        key_history[0] <= key_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'b0, held_report};

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("output or input stage valid after reset");

  a_report_needs_latch: assert property (@(posedge clk) disable iff (rst)
    held_report != KC_NONE |-> press_latched)
    else $error("key reported without latch set");

  a_latch_rise_reports: assert property (@(posedge clk) disable iff (rst)
    $rose(press_latched) |-> m_tvalid && held_report != KC_NONE
      && held_report == key_history[0])
    else $error("latch set without a key report");

  a_latched_history_frozen: assert property (@(posedge clk) disable iff (rst)
    $past(press_latched) && press_latched |-> $stable(key_history[0]))
    else $error("history moved while latched");

  a_result_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(held_report))
    else $error("stalled result changed");

endmodule

FILE: design/alkd_classify.sv
// Window classifier: maps one ladder sample to a key code.
module alkd_classify import alkd_pkg::*; (
  input  sample_t sample,
  input  logic    keys_enabled,
  output key_t    key_code
);

  always_comb begin
    key_code = KC_NONE;
    if (in_window(sample, POWER_LO, POWER_HI)) begin
      key_code = KC_POWER;
    end else if (keys_enabled) begin
      if (in_window(sample, MODE_LO, MODE_HI)) begin
        key_code = KC_MODE;
      end else if (in_window(sample, SET_LO, SET_HI)) begin
        key_code = KC_SET;
      end else if (in_window(sample, PRINT_LO, PRINT_HI)) begin
        key_code = KC_PRINT;
      end else if (in_window(sample, TARE_LO, TARE_HI)) begin
        key_code = KC_TARE;
      end else if (in_window(sample, CAL_LO, CAL_HI)) begin
        key_code = KC_CAL;
      end
    end
  end

endmodule

FILE: bench/adc_ladder_key_decoder_core_tb.sv
// Self-checking testbench for the ladder key decoder core: random samples, stalls and checks.
module adc_ladder_key_decoder_core_tb;
  import alkd_pkg::*;

  localparam int IdleLimit = 4000;

  typedef enum logic [1:0] {RX_FULL, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;   // [15:0] sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;              // [2:0] key_code, [7:3] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_KEYS_ENABLED;
  logic [15:0] cfg_data = 16'h0000;

  // Decoder state as the bench sees it
  logic    model_keys_en = 1'b0;
  sample_t model_level   = RELEASE_LEVEL_RST;
  key_t    history [3]   = '{KC_NONE, KC_NONE, KC_NONE};
  logic    latched       = 1'b0;
  key_t    held_key      = KC_NONE;

  sample_t sample_queue [$];
  key_t    expected_keys [$];
  int      error_count = 0;

  int       burst_left = 1;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_FULL;
  int       seg_left = 0;
  int       rx_phase = 0;
  int       rx_beats = 0;
  int       hold_left = 0;
  int       next_hold_at = 200;
  int       idle_cycles = 0;

  adc_ladder_key_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic key_t classify(sample_t s);
    if (s > POWER_LO && s < POWER_HI) return KC_POWER;
    if (!model_keys_en) return KC_NONE;
    if (s > MODE_LO && s < MODE_HI) return KC_MODE;
    if (s > SET_LO && s < SET_HI) return KC_SET;
    if (s > PRINT_LO && s < PRINT_HI) return KC_PRINT;
    if (s > TARE_LO && s < TARE_HI) return KC_TARE;
    if (s > CAL_LO && s < CAL_HI) return KC_CAL;
    return KC_NONE;
  endfunction

  // Advance the debounce state by one sample and queue the key it reports
  task automatic decode_sample(sample_t s);
    key_t k;
    if (s < model_level) begin
      held_key = KC_NONE;
      latched = 1'b0;
    end else if (s > model_level && !latched) begin
      k = classify(s);
      if (k != KC_NONE) begin
        history[2] = history[1];
        history[1] = history[0];
        history[0] = k;
        if (history[1] == k && history[2] == k) begin
          held_key = k;
          latched = 1'b1;
        end
      end
    end else begin
      held_key = KC_NONE;
    end
    expected_keys.push_back(held_key);
  endtask

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  function automatic void window_bounds(input key_t k, output sample_t lo, output sample_t hi);
    case (k)
      KC_MODE: begin
        lo = MODE_LO; hi = MODE_HI;
      end
      KC_SET: begin
        lo = SET_LO; hi = SET_HI;
      end
      KC_PRINT: begin
        lo = PRINT_LO; hi = PRINT_HI;
      end
      KC_TARE: begin
        lo = TARE_LO; hi = TARE_HI;
      end
      KC_CAL: begin
        lo = CAL_LO; hi = CAL_HI;
      end
      default: begin
        lo = POWER_LO; hi = POWER_HI;
      end
    endcase
  endfunction

  // Mostly inside the window, now and then right on or next to an edge
  function automatic sample_t window_sample(key_t k);
    sample_t lo;
    sample_t hi;
    int      r;
    window_bounds(k, lo, hi);
    r = $urandom_range(0, 39);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return lo + 16'd1;
    if (r == 3) return hi - 16'd1;
    return lo + 16'd1 + sample_t'($urandom_range(0, int'(hi - lo) - 2));
  endfunction

  function automatic sample_t release_sample();
    if (model_level == 16'h0000) return model_level;
    if ($urandom_range(0, 4) == 0) return model_level - 16'd1;
    return sample_t'($urandom_range(0, int'(model_level) - 1));
  endfunction

  function automatic sample_t noise_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return model_level;
      3: return model_level + 16'd1;
      4: return model_level - 16'd1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // One key press: release, settle on a key with the odd glitch, hold, release
  task automatic add_press();
    key_t k;
    k = key_t'($urandom_range(int'(KC_POWER), int'(KC_CAL)));
    repeat ($urandom_range(0, 2)) sample_queue.push_back(release_sample());
    repeat ($urandom_range(2, 5)) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) sample_queue.push_back(noise_sample());
        else sample_queue.push_back(
            window_sample(key_t'($urandom_range(int'(KC_POWER), int'(KC_CAL)))));
      end else begin
        sample_queue.push_back(window_sample(k));
      end
    end
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) sample_queue.push_back(noise_sample());
      else sample_queue.push_back(window_sample(k));
    end
    if ($urandom_range(0, 5) == 0) sample_queue.push_back(model_level);
    repeat ($urandom_range(1, 2)) sample_queue.push_back(release_sample());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || expected_keys.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEYS_ENABLED) model_keys_en = val[0];
    else model_level = val;
  endtask

  task automatic run_phase(logic en, sample_t lvl, int count);
    wait_idle();
    write_reg(CFG_KEYS_ENABLED, {15'd0, en});
    write_reg(CFG_RELEASE_LEVEL, lvl);
    @(negedge clk);
    while (sample_queue.size() < count) begin
      if ($urandom_range(0, 4) == 0) sample_queue.push_back(noise_sample());
      else add_press();
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Reset settings: edges, equal level, power press, latched hold, release
    sample_queue = '{16'h0000, 16'h2000, 16'hFFFF, 16'h2A00, 16'h2A01, 16'h2EFE,
                     16'h2C00, 16'h2C00, 16'h1FFF};
    wait_idle();
    write_reg(CFG_KEYS_ENABLED, 16'h0001);
    @(negedge clk);
    // Every other key once, released in between
    sample_queue = '{16'h5401, 16'h55FE, 16'h5500, 16'h0000,
                     16'hFD01, 16'hFEFE, 16'hFE00, 16'h1FFF,
                     16'h7A01, 16'h7CFE, 16'h7B00, 16'h0100,
                     16'hA101, 16'hA3FE, 16'hA200, 16'h0000,
                     16'hCC01, 16'hCDFE, 16'hCD00};
    run_phase(1'b1, 16'h2000, 170);
    run_phase(1'b0, 16'h2000, 150);
    run_phase(1'b1, 16'h0000, 60);
    run_phase(1'b1, 16'hFFFF, 60);
    run_phase(1'b0, 16'h3000, 100);   // power window lies below the level
    run_phase(1'b1, 16'h5500, 120);   // level inside the mode window
    run_phase(1'b1, 16'h0001, 100);
    run_phase(1'b1, sample_t'($urandom_range(16'h0800, 16'h2900)), 170);
    run_phase(1'b1, 16'h2000, 170);
    wait_idle();
    if (error_count == 0) begin
      $display("adc_ladder_key_decoder_core_tb: clean");
    end else begin
      $display("adc_ladder_key_decoder_core_tb: errors");
    end
    $finish;
  end

  // Sender: bursts of random length with random gaps
  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_sample(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes per segment, with a long hold-off now and then
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_beats++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_beats >= next_hold_at) begin
        hold_left = 160;
        next_hold_at += 450;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        rx_phase++;
        case (rx_mode)
          RX_FULL:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= (rx_phase[1:0] == 2'b00);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    key_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_keys.size() == 0) begin
        report_mismatch("unexpected beat", 8'h00, m_tdata);
      end else begin
        want = expected_keys.pop_front();
        if (m_tdata !== {5'b00000, want}) report_mismatch("key_code", {5'b00000, want}, m_tdata);
      end
    end
  end

  // End the run if no channel moves a beat for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("adc_ladder_key_decoder_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: sim.f
design/alkd_pkg.sv
design/alkd_classify.sv
design/adc_ladder_key_decoder_core.sv
bench/adc_ladder_key_decoder_core_tb.sv
